@@ rtl/dpl_pkg.sv @@
// ----------------------------------------------------------------------------
// dpl_pkg
// Shared widths, register indexes, reset values and constant tables for the
// dual-phase morphing LFO.
// ----------------------------------------------------------------------------
package dpl_pkg;

   // Shared multiplier operand width
   localparam int MUL_W = 32;

   // Default phase accumulator width
   localparam int PHASE_BITS_DEF = 32;

   // Stream field widths
   localparam int CV_W    = 16;
   localparam int LEVEL_W = 16;
   localparam int REQ_W   = 3 * CV_W;
   localparam int RSP_W   = 2 * LEVEL_W;

   // Control register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_STEP_PER_HERTZ = 3'd0;
   localparam csr_idx_type REG_FREQ_KNOB      = 3'd1;
   localparam csr_idx_type REG_FREQ_CV_GAIN   = 3'd2;
   localparam csr_idx_type REG_SWING_KNOB     = 3'd3;
   localparam csr_idx_type REG_SWING_CV_GAIN  = 3'd4;
   localparam csr_idx_type REG_SHAPE_KNOB     = 3'd5;
   localparam csr_idx_type REG_SHAPE_CV_GAIN  = 3'd6;

   // Register reset values
   localparam logic [30:0] RST_STEP_PER_HERTZ = 31'd89478;
   localparam logic [13:0] RST_FREQ_KNOB      = 14'd1024;
   localparam logic [15:0] RST_SHAPE_KNOB     = 16'd16384;

   // Exponent limits, 1/1024 octave
   localparam logic signed [17:0] EXP_MIN  = -18'sd8192;
   localparam logic signed [17:0] EXP_MAX  = 18'sd12288;
   localparam logic signed [15:0] EXP_BIAS = 16'sd8192;
   localparam logic [5:0]         SHIFT_BASE = 6'd38;

   // Swing and shape are held in [0, 1.0] Q15
   localparam logic [15:0] UNIT_Q15 = 16'd32768;
   localparam logic [15:0] HALF_Q15 = 16'd16384;

   // Fraction product: unity in Q30, rounding term, last table row
   localparam logic [30:0] M_ONE     = 31'h4000_0000;
   localparam logic [62:0] M_ROUND   = 63'h2000_0000;
   localparam logic [3:0]  FRAC_LAST = 4'd9;

   // Pulse width: 0.01 + 0.29*shape in Q0.32
   localparam logic [31:0] PW_BASE  = 32'd42949673;
   localparam logic [31:0] PW_SLOPE = 32'd1245540516;

   // Waveform constants
   localparam logic [17:0] TRI_TOP  = 18'd131072;
   localparam logic [16:0] RAMP_TOP = 17'd65536;
   localparam logic [15:0] LEVEL_MAX = 16'hFFFF;
   localparam logic [15:0] LEVEL_MID = 16'h8000;

   // 2^(2^k/1024) in Q30
   function automatic logic [30:0] frac_pow(input logic [3:0] k);
      logic [30:0] v;
      case (k)
         4'd0:    v = 31'd1074468888;
         4'd1:    v = 31'd1075196443;
         4'd2:    v = 31'd1076653033;
         4'd3:    v = 31'd1079572136;
         4'd4:    v = 31'd1085434106;
         4'd5:    v = 31'd1097253708;
         4'd6:    v = 31'd1121280436;
         4'd7:    v = 31'd1170923762;
         4'd8:    v = 31'd1276901417;
         4'd9:    v = 31'd1518500250;
         default: v = M_ONE;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/swing_dual_phase_lfo_unit.sv @@
// ----------------------------------------------------------------------------
// swing_dual_phase_lfo_unit
// Dual-phase morphing LFO with swing. Each request carries three control
// voltages; the unit advances its phase accumulator and returns one averaged
// morphing saw level and one averaged pulse level.
//
//  channel | dir | transfer on           | payload
//  --------+-----+-----------------------+-----------------------------------
//  req_    | in  | req_tvalid&req_tready | freq_cv, swing_cv, shape_cv
//  rsp_    | out | rsp_tvalid&rsp_tready | saw_level, pulse_level
//  csr_    | in  | csr_valid&csr_ready   | register index, write data
//
// The sequencer steps the single shared 32x32 multiplier through the CV,
// exp2 fraction, step, pulse width and waveform products, with one extra
// fraction update for each set bit in the exponent fraction. A new request
// is taken only once the sequencer is back in idle after the previous
// result has been loaded; req_tready is high only while the sequencer is
// idle. The result sits in an output register; a stalled rsp_ side holds the
// sequencer in its final state. Reset is synchronous and clears the phase and
// the registers to their defaults; csr_ writes are always taken.
// ----------------------------------------------------------------------------
module swing_dual_phase_lfo_unit #(
   parameter int PHASE_BITS = dpl_pkg::PHASE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: freq_cv [15:0], swing_cv [31:16], shape_cv [47:32]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dpl_pkg::REQ_W-1:0]          req_tdata,
   // rsp_tdata: saw_level [15:0], pulse_level [31:16]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dpl_pkg::RSP_W-1:0]          rsp_tdata,
   // control register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dpl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dpl_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PB = PHASE_BITS;

   // Sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SWCV  = 4'd1;
   localparam logic [3:0] S_SHCV  = 4'd2;
   localparam logic [3:0] S_SHP   = 4'd3;
   localparam logic [3:0] S_FISS  = 4'd4;
   localparam logic [3:0] S_FUPD  = 4'd5;
   localparam logic [3:0] S_STEP  = 4'd6;
   localparam logic [3:0] S_SHIFT = 4'd7;
   localparam logic [3:0] S_ADV   = 4'd8;
   localparam logic [3:0] S_SA1   = 4'd9;
   localparam logic [3:0] S_SA2   = 4'd10;
   localparam logic [3:0] S_SB1   = 4'd11;
   localparam logic [3:0] S_SB2   = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   // Control registers
   logic [30:0]        step_per_hertz_ff;
   logic signed [13:0] freq_knob_ff;
   logic signed [16:0] freq_cv_gain_ff;
   logic [15:0]        swing_knob_ff;
   logic signed [16:0] swing_cv_gain_ff;
   logic [15:0]        shape_knob_ff;
   logic signed [16:0] shape_cv_gain_ff;

   // Sequencer and working registers
   logic [3:0]         state_ff;
   logic [3:0]         k_ff;
   logic signed [15:0] swing_cv_ff;
   logic signed [15:0] shape_cv_ff;
   logic [9:0]         frac_ff;
   logic [5:0]         sh_ff;
   logic [15:0]        swing_ff;
   logic [15:0]        shape_ff;
   logic [30:0]        m_ff;
   logic [PB-1:0]      step_ff;
   logic [PB-1:0]      phase_ff;
   logic [PB-1:0]      second_ff;
   logic [31:0]        width_ff;
   logic [31:0]        acc_ff;
   logic [16:0]        saw_a_ff;

   // Output register
   logic                      rsp_tvalid_ff;
   logic [dpl_pkg::RSP_W-1:0] rsp_tdata_ff;

   // Shared multiplier
   logic                                 mul_en;
   logic signed [dpl_pkg::MUL_W-1:0]     mul_a;
   logic signed [dpl_pkg::MUL_W-1:0]     mul_b;
   logic signed [2*dpl_pkg::MUL_W-1:0]   mul_p;

   logic req_xfer;
   logic rsp_load;

   // Request fields
   logic signed [15:0] req_freq_cv;
   logic signed [15:0] req_swing_cv;
   logic signed [15:0] req_shape_cv;

   assign req_freq_cv  = $signed(req_tdata[15:0]);
   assign req_swing_cv = $signed(req_tdata[31:16]);
   assign req_shape_cv = $signed(req_tdata[47:32]);

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------------
   // Control register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         step_per_hertz_ff <= dpl_pkg::RST_STEP_PER_HERTZ;
         freq_knob_ff      <= $signed(dpl_pkg::RST_FREQ_KNOB);
         freq_cv_gain_ff   <= '0;
         swing_knob_ff     <= '0;
         swing_cv_gain_ff  <= '0;
         shape_knob_ff     <= dpl_pkg::RST_SHAPE_KNOB;
         shape_cv_gain_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            dpl_pkg::REG_STEP_PER_HERTZ: step_per_hertz_ff <= csr_data[30:0];
            dpl_pkg::REG_FREQ_KNOB:      freq_knob_ff      <= $signed(csr_data[13:0]);
            dpl_pkg::REG_FREQ_CV_GAIN:   freq_cv_gain_ff   <= $signed(csr_data[16:0]);
            dpl_pkg::REG_SWING_KNOB:     swing_knob_ff     <= csr_data[15:0];
            dpl_pkg::REG_SWING_CV_GAIN:  swing_cv_gain_ff  <= $signed(csr_data[16:0]);
            dpl_pkg::REG_SHAPE_KNOB:     shape_knob_ff     <= csr_data[15:0];
            dpl_pkg::REG_SHAPE_CV_GAIN:  shape_cv_gain_ff  <= $signed(csr_data[16:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Frequency exponent from the freq CV product: floor(prod*10/2^20)
   logic signed [32:0] fcv_prod;
   logic signed [36:0] fcv_x10;
   logic signed [16:0] fcv_oct;
   logic signed [17:0] e_sum;
   logic signed [15:0] e_cl;
   logic [14:0]        e_bias;
   logic [4:0]         oct_idx;
   logic [5:0]         sh_in;

   always_comb begin
      fcv_prod = $signed(mul_p[32:0]);
      fcv_x10  = (37'(fcv_prod) <<< 3) + (37'(fcv_prod) <<< 1);
      fcv_oct  = $signed(fcv_x10[36:20]);
      e_sum    = 18'(freq_knob_ff) + 18'(fcv_oct);
      if (e_sum < dpl_pkg::EXP_MIN) begin
         e_cl = 16'(dpl_pkg::EXP_MIN);
      end else if (e_sum > dpl_pkg::EXP_MAX) begin
         e_cl = 16'(dpl_pkg::EXP_MAX);
      end else begin
         e_cl = 16'(e_sum);
      end
      e_bias  = 15'(e_cl + dpl_pkg::EXP_BIAS);
      oct_idx = e_bias[14:10];
      sh_in   = dpl_pkg::SHIFT_BASE - 6'(oct_idx);
   end

   // ---------------------------------------------------------------------
   // Knob plus scaled CV, clamped to [0, 1.0]; swing and shape share this
   logic [15:0]        kc_knob;
   logic signed [17:0] kc_cv;
   logic signed [18:0] kc_sum;
   logic [15:0]        kc_in;

   always_comb begin
      kc_knob = (state_ff == S_SHCV) ? swing_knob_ff : shape_knob_ff;
      kc_cv   = $signed(mul_p[32:15]);
      kc_sum  = $signed({3'b000, kc_knob}) + 19'(kc_cv);
      if (kc_sum < 19'sd0) begin
         kc_in = '0;
      end else if (kc_sum > $signed({3'b000, dpl_pkg::UNIT_Q15})) begin
         kc_in = dpl_pkg::UNIT_Q15;
      end else begin
         kc_in = kc_sum[15:0];
      end
   end

   // ---------------------------------------------------------------------
   // Fraction update with rounding, step shift and saturation
   logic [62:0] m_rnd;
   logic [30:0] m_in;
   logic [61:0] stp_sh;
   logic [30:0] stp_sat;
   logic [PB-1:0] step_in;

   always_comb begin
      m_rnd   = 63'(mul_p[61:0]) + dpl_pkg::M_ROUND;
      m_in    = m_rnd[60:30];
      stp_sh  = mul_p[61:0] >> sh_ff;
      stp_sat = (|stp_sh[61:31]) ? '1 : stp_sh[30:0];
   end

   // Rescale Q0.32 values and phase offsets to the accumulator width
   logic [PB-1:0] sw_off;
   logic [PB-1:0] half_turn;
   logic [31:0]   phase_q32;
   logic [31:0]   second_q32;

   assign half_turn = PB'(1) << (PB - 1);

   if (PB >= 32) begin : g_wide
      assign step_in    = PB'(stp_sat) << (PB - 32);
      assign phase_q32  = phase_ff[PB-1 -: 32];
      assign second_q32 = second_ff[PB-1 -: 32];
   end else begin : g_narrow
      assign step_in    = PB'(stp_sat >> (32 - PB));
      assign phase_q32  = 32'(phase_ff) << (32 - PB);
      assign second_q32 = 32'(second_ff) << (32 - PB);
   end

   if (PB >= 17) begin : g_off_wide
      assign sw_off = PB'(swing_ff) << (PB - 17);
   end else begin : g_off_narrow
      assign sw_off = PB'(swing_ff >> 1);
   end

   // ---------------------------------------------------------------------
   // Waveform operands: saw/triangle blend below half shape, triangle/ramp
   // blend above
   logic        use_b;
   logic [15:0] wav_p;
   logic [16:0] wav_tri;
   logic [16:0] wav_ramp;
   logic [16:0] wav_x;
   logic [16:0] wav_y;
   logic [16:0] shape_x2;
   logic [15:0] coef_m;
   logic [15:0] coef_inv;

   always_comb begin
      use_b    = (state_ff == S_SB1) || (state_ff == S_SB2);
      wav_p    = use_b ? second_ff[PB-1 -: 16] : phase_ff[PB-1 -: 16];
      wav_tri  = wav_p[15] ? 17'(dpl_pkg::TRI_TOP - {1'b0, wav_p, 1'b0}) : {wav_p, 1'b0};
      wav_ramp = dpl_pkg::RAMP_TOP - 17'(wav_p);
      shape_x2 = {shape_ff, 1'b0};
      if (shape_ff < dpl_pkg::HALF_Q15) begin
         wav_x  = 17'(wav_p);
         wav_y  = wav_tri;
         coef_m = shape_x2[15:0];
      end else begin
         wav_x  = wav_tri;
         wav_y  = wav_ramp;
         coef_m = 16'(shape_x2 - 17'(dpl_pkg::UNIT_Q15));
      end
      coef_inv = dpl_pkg::UNIT_Q15 - coef_m;
   end

   // Accumulated blend, Q15 down to level
   logic [31:0] saw_sum;
   logic [16:0] saw_val;

   assign saw_sum = acc_ff + mul_p[31:0];
   assign saw_val = saw_sum[31:15];

   // ---------------------------------------------------------------------
   // Multiplier operand selection
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_IDLE: begin
            mul_en = req_xfer;
            mul_a  = 32'(req_freq_cv);
            mul_b  = 32'(freq_cv_gain_ff);
         end
         S_SWCV: begin
            mul_en = 1'b1;
            mul_a  = 32'(swing_cv_ff);
            mul_b  = 32'(swing_cv_gain_ff);
         end
         S_SHCV: begin
            mul_en = 1'b1;
            mul_a  = 32'(shape_cv_ff);
            mul_b  = 32'(shape_cv_gain_ff);
         end
         S_FISS: begin
            mul_en = frac_ff[k_ff];
            mul_a  = $signed(32'(m_ff));
            mul_b  = $signed(32'(dpl_pkg::frac_pow(k_ff)));
         end
         S_STEP: begin
            mul_en = 1'b1;
            mul_a  = $signed(32'(step_per_hertz_ff));
            mul_b  = $signed(32'(m_ff));
         end
         S_ADV: begin
            mul_en = 1'b1;
            mul_a  = $signed(32'(shape_ff));
            mul_b  = $signed(dpl_pkg::PW_SLOPE);
         end
         S_SA1, S_SB1: begin
            mul_en = 1'b1;
            mul_a  = $signed(32'(wav_x));
            mul_b  = $signed(32'(coef_inv));
         end
         S_SA2, S_SB2: begin
            mul_en = 1'b1;
            mul_a  = $signed(32'(wav_y));
            mul_b  = $signed(32'(coef_m));
         end
         default: ;
      endcase
   end

   dpl_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .mul_p  (mul_p)
   );

   // ---------------------------------------------------------------------
   // Result: averaged saw and averaged pulse of both phases
   logic [17:0] avg_sum;
   logic [15:0] saw_level_in;
   logic        pulse_a;
   logic        pulse_b;
   logic [15:0] pulse_level_in;

   always_comb begin
      avg_sum      = 18'(saw_a_ff) + 18'(saw_val) + 18'd1;
      saw_level_in = avg_sum[17] ? dpl_pkg::LEVEL_MAX
                   : (avg_sum[16:1] == 16'd0 && avg_sum[17:1] != 17'd0)
                     ? dpl_pkg::LEVEL_MAX : avg_sum[16:1];
      pulse_a      = phase_q32 < width_ff;
      pulse_b      = second_q32 < width_ff;
      if (pulse_a && pulse_b) begin
         pulse_level_in = dpl_pkg::LEVEL_MAX;
      end else if (pulse_a || pulse_b) begin
         pulse_level_in = dpl_pkg::LEVEL_MID;
      end else begin
         pulse_level_in = '0;
      end
   end

   assign rsp_load = (state_ff == S_FIN) && (!rsp_tvalid_ff || rsp_tready);

   // ---------------------------------------------------------------------
   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:  if (req_xfer) state_ff <= S_SWCV;
            S_SWCV:  state_ff <= S_SHCV;
            S_SHCV:  state_ff <= S_SHP;
            S_SHP:   state_ff <= S_FISS;
            S_FISS: begin
               if (frac_ff[k_ff]) begin
                  state_ff <= S_FUPD;
               end else if (k_ff == dpl_pkg::FRAC_LAST) begin
                  state_ff <= S_STEP;
               end
            end
            S_FUPD:  state_ff <= (k_ff == dpl_pkg::FRAC_LAST) ? S_STEP : S_FISS;
            S_STEP:  state_ff <= S_SHIFT;
            S_SHIFT: state_ff <= S_ADV;
            S_ADV:   state_ff <= S_SA1;
            S_SA1:   state_ff <= S_SA2;
            S_SA2:   state_ff <= S_SB1;
            S_SB1:   state_ff <= S_SB2;
            S_SB2:   state_ff <= S_FIN;
            S_FIN:   if (rsp_load) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Fraction bit counter
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         k_ff <= '0;
      end else if ((state_ff == S_FISS && !frac_ff[k_ff] && k_ff != dpl_pkg::FRAC_LAST)
                || (state_ff == S_FUPD && k_ff != dpl_pkg::FRAC_LAST)) begin
         k_ff <= k_ff + 4'd1;
      end
   end

   // Working registers, loaded as products come back
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         swing_cv_ff <= req_swing_cv;
         shape_cv_ff <= req_shape_cv;
         m_ff        <= dpl_pkg::M_ONE;
      end
      case (state_ff)
         S_SWCV: begin
            frac_ff <= e_bias[9:0];
            sh_ff   <= sh_in;
         end
         S_SHCV:  swing_ff <= kc_in;
         S_SHP:   shape_ff <= kc_in;
         S_FUPD:  m_ff     <= m_in;
         S_SHIFT: step_ff  <= step_in;
         S_SA1: begin
            width_ff  <= dpl_pkg::PW_BASE + mul_p[46:15];
            second_ff <= phase_ff + half_turn - sw_off;
         end
         S_SA2:   acc_ff   <= mul_p[31:0];
         S_SB1:   saw_a_ff <= saw_val;
         S_SB2:   acc_ff   <= mul_p[31:0];
         default: ;
      endcase
   end

   // Phase accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (state_ff == S_ADV) begin
         phase_ff <= phase_ff + step_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {pulse_level_in, saw_level_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   // One request in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another was in flight");

   // Fraction product stays in [1.0, 2.0) Q30 while working
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> m_ff[30])
      else $error("exp2 fraction product left its range");

   // Fraction counter never passes the last table row
   a_frac_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FISS || state_ff == S_FUPD) |-> (k_ff <= dpl_pkg::FRAC_LAST))
      else $error("fraction counter overran the table");

   // A new result appears only out of the final state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside the final state");
`endif

endmodule

@@ rtl/dpl_mul.sv @@
// ----------------------------------------------------------------------------
// dpl_mul
// Shared signed multiplier with a registered product. The product register
// loads only when an operation is issued, so a result holds until consumed.
// ----------------------------------------------------------------------------
module dpl_mul (
   input  logic                                  clock,
   input  logic                                  mul_en,
   input  logic signed [dpl_pkg::MUL_W-1:0]      mul_a,
   input  logic signed [dpl_pkg::MUL_W-1:0]      mul_b,
   output logic signed [2*dpl_pkg::MUL_W-1:0]    mul_p
);

   logic signed [2*dpl_pkg::MUL_W-1:0] mul_p_ff;

   // Product register
   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_p_ff <= mul_a * mul_b;
      end
   end

   assign mul_p = mul_p_ff;

endmodule
